// File: src/spjq_pkg.sv
package spjq_pkg;

    // Default sizing
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths on the stream ports
    localparam int NUM_W   = 16;
    localparam int FIELD_W = 16;
    localparam int PRIO_PORT_W = FIELD_W + 1;

    typedef enum logic {
        MODE_ENQUEUE = 1'b0,
        MODE_DEQUEUE = 1'b1
    } spjq_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spjq_status_t;

    // Shift command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic remove;
    } spjq_op_t;

endpackage

// File: src/spjq_cell.sv
module spjq_cell #(
    parameter int ENTRY_W = spjq_pkg::NUM_W + 3 * spjq_pkg::VALUE_WIDTH_DEF + 1,
    parameter int PRIO_W  = spjq_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic               aclk,
    input  spjq_pkg::spjq_op_t op,
    input  logic               occupied,
    input  logic [ENTRY_W-1:0] new_entry,
    input  logic [ENTRY_W-1:0] left_entry,
    input  logic               left_keep,
    input  logic [ENTRY_W-1:0] right_entry,
    output logic [ENTRY_W-1:0] entry,
    output logic               keep
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    // Hold position when the stored job ranks at or above the incoming one
    assign keep  = occupied &&
                   (entry_reg[ENTRY_W-1 -: PRIO_W] >= new_entry[ENTRY_W-1 -: PRIO_W]);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (op.insert) begin
            if (!keep) begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end else if (op.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: src/sorted_priority_job_queue.sv
// Sorted priority job queue over a row of compare-and-shift cells.
// A result is registered and is on m_tdata in the cycle after its request is taken.
// Throughput: one request per cycle unless m_tready stalls; every cell compares
// against the new job and shifts in the same cycle: one pass per insert or remove.
// Reset (aresetn low, synchronous): queue empty, next job number 1, no result
// pending. Cell contents are not cleared; the entry count marks which are live.
module sorted_priority_job_queue #(
    parameter int QUEUE_DEPTH = spjq_pkg::QUEUE_DEPTH_DEF,
    parameter int VALUE_WIDTH = spjq_pkg::VALUE_WIDTH_DEF,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
    localparam int M_DATA_W   = ((3 * spjq_pkg::FIELD_W + spjq_pkg::PRIO_PORT_W + 1
                                  + CNT_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] job_depth, [31:16] job_traffic
    input  logic [2*spjq_pkg::FIELD_W-1:0]   s_tdata,
    // [0] mode
    input  logic [0:0]                       s_tuser,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] job_number, [31:16] out_depth, [47:32] out_traffic,
    // [64:48] out_priority, [65] is_empty, [65+CNT_W:66] entry_count, zero fill above
    output logic [M_DATA_W-1:0]              m_tdata,
    // [1:0] status
    output logic [1:0]                       m_tuser
);

    localparam int NUM_W   = spjq_pkg::NUM_W;
    localparam int PRIO_W  = VALUE_WIDTH + 1;
    // Entry layout, lowest bits first: number, depth, traffic, priority
    localparam int ENTRY_W = NUM_W + 2 * VALUE_WIDTH + PRIO_W;

    // Control and result registers
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [NUM_W-1:0]          next_number_reg;
    logic [NUM_W-1:0]          next_number_next;
    spjq_pkg::spjq_status_t    status_reg;
    spjq_pkg::spjq_status_t    status_next;
    logic [ENTRY_W-1:0]        result_reg;
    logic [ENTRY_W-1:0]        result_next;

    logic                      accept;
    spjq_pkg::spjq_mode_t      mode;
    logic [VALUE_WIDTH-1:0]    in_depth;
    logic [VALUE_WIDTH-1:0]    in_traffic;
    logic [PRIO_W-1:0]         in_prio;
    logic [ENTRY_W-1:0]        new_entry;
    logic                      is_full;
    logic                      is_empty_now;
    spjq_pkg::spjq_op_t        op;

    logic [ENTRY_W-1:0]        cell_entry [QUEUE_DEPTH];
    logic                      cell_keep  [QUEUE_DEPTH];

    // Take a request whenever the result register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign mode       = spjq_pkg::spjq_mode_t'(s_tuser[0]);
    assign in_depth   = s_tdata[VALUE_WIDTH-1:0];
    assign in_traffic = s_tdata[spjq_pkg::FIELD_W +: VALUE_WIDTH];
    assign in_prio    = PRIO_W'(in_depth) + PRIO_W'(in_traffic);
    assign new_entry  = {in_prio, in_traffic, in_depth, next_number_reg};

    assign is_full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty_now = (count_reg == '0);

    // Broadcast the shift command; a rejected request leaves the row alone
    always_comb begin
        op.insert = accept && (mode == spjq_pkg::MODE_ENQUEUE) && !is_full;
        op.remove = accept && (mode == spjq_pkg::MODE_DEQUEUE) && !is_empty_now;
    end

    // Row of cells: cell 0 is the front of the queue
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [ENTRY_W-1:0] left_entry;
        logic               left_keep;
        logic [ENTRY_W-1:0] right_entry;
        logic               occupied;

        if (i == 0) begin : g_front
            assign left_entry = new_entry;
            assign left_keep  = 1'b1;
        end else begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_back
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        assign occupied = (CNT_W'(i) < count_reg);

        spjq_cell #(
            .ENTRY_W (ENTRY_W),
            .PRIO_W  (PRIO_W)
        ) u_cell (
            .aclk        (aclk),
            .op          (op),
            .occupied    (occupied),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_keep   (left_keep),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // Result selection, count and job number
    always_comb begin
        m_valid_next     = m_valid_reg;
        count_next       = count_reg;
        next_number_next = next_number_reg;
        status_next      = status_reg;
        result_next      = result_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next = 1'b1;
            if (mode == spjq_pkg::MODE_ENQUEUE) begin
                if (is_full) begin
                    // Echo the request, consume no number
                    status_next = spjq_pkg::STATUS_FULL;
                    result_next = {in_prio, in_traffic, in_depth, {NUM_W{1'b0}}};
                end else begin
                    status_next      = spjq_pkg::STATUS_OK;
                    result_next      = new_entry;
                    count_next       = count_reg + 1'b1;
                    next_number_next = next_number_reg + 1'b1;
                end
            end else begin
                if (is_empty_now) begin
                    status_next = spjq_pkg::STATUS_EMPTY;
                    result_next = '0;
                end else begin
                    status_next = spjq_pkg::STATUS_OK;
                    result_next = cell_entry[0];
                    count_next  = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            count_reg       <= '0;
            next_number_reg <= NUM_W'(1);
        end else begin
            m_valid_reg     <= m_valid_next;
            count_reg       <= count_next;
            next_number_reg <= next_number_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        result_reg <= result_next;
    end

    // count_reg tracks the item held in the result register
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = M_DATA_W'({
        count_reg,
        is_empty_now,
        spjq_pkg::PRIO_PORT_W'(result_reg[ENTRY_W-1 -: PRIO_W]),
        spjq_pkg::FIELD_W'(result_reg[NUM_W + VALUE_WIDTH +: VALUE_WIDTH]),
        spjq_pkg::FIELD_W'(result_reg[NUM_W +: VALUE_WIDTH]),
        result_reg[NUM_W-1:0]
    });

    // Occupancy never exceeds the row length
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // Front two live cells stay in descending priority
    a_front_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |->
        (cell_entry[0][ENTRY_W-1 -: PRIO_W] >= cell_entry[1][ENTRY_W-1 -: PRIO_W]))
        else $error("front cells out of priority order");

    // A rejected enqueue is reported only with the row full
    a_full_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == spjq_pkg::STATUS_FULL)) |->
        (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with free cells");

    // A dequeue on empty is reported only with no entries
    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == spjq_pkg::STATUS_EMPTY)) |-> is_empty_now)
        else $error("empty status with live entries");

    // An accepted enqueue advances the job number by one
    a_number_step: assert property (@(posedge aclk) disable iff (!aresetn)
        op.insert |=> (next_number_reg == $past(next_number_reg) + NUM_W'(1)))
        else $error("job number not advanced");

endmodule
